/* hdl/mst_pkg.sv */
// Shared constants and codes for the multi-slot timer scheduler.
package mst_pkg;

   localparam int NUM_SLOTS_DEFAULT = 16;
   localparam int TICK_BITS_DEFAULT = 32;

   localparam int ACTION_W = 2;
   localparam int SLOT_W   = 4;
   localparam int AMOUNT_W = 32;
   localparam int DELAY_W  = 31;
   localparam int STAMP_W  = 32;

   // most timers fired by one tick
   localparam int MAX_FIRES = 16;
   localparam int FIRE_CNT_W = $clog2(MAX_FIRES + 1);

   localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

   localparam logic [ACTION_W-1:0] ACT_START_ONESHOT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_START_PERIODIC = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP           = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_TICK           = 2'd3;

endpackage

/* hdl/mst_req_if.sv */
// Request channel: action, slot and amount with valid/ready.
interface mst_req_if import mst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SLOT_W-1:0]   slot;
   logic [AMOUNT_W-1:0] amount;

   modport source (output valid, output action, output slot, output amount, input ready);
   modport sink   (input valid, input action, input slot, input amount, output ready);
endinterface

/* hdl/mst_rsp_if.sv */
// Response channel: fired timer report with valid/ready.
interface mst_rsp_if import mst_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               fired_valid;
   logic [SLOT_W-1:0]  fired_slot;
   logic               last;
   logic [DELAY_W-1:0] next_delay;
   logic               slot_active;

   modport source (output valid, output fired_valid, output fired_slot, output last,
                   output next_delay, output slot_active, input ready);
   modport sink   (input valid, input fired_valid, input fired_slot, input last,
                   input next_delay, input slot_active, output ready);
endinterface

/* hdl/multi_slot_timer_scheduler.sv */
// Timer slot table with a sequential earliest-deadline scan and fire/reload sequencer.
//
//   channel   dir  handshake        carries
//   req_if    in   valid/ready      action, slot, amount
//   rsp_if    out  valid/ready      fired_valid, fired_slot, last, next_delay, slot_active
//
// Start/stop: after the request is taken the sequencer passes through ST_DONE, which loads
// the response once rsp_if is free. Tick: each scan runs over all slots through the single
// comparator; a tick firing F timers rescans after each fire, and the next request is taken
// only after the last response is loaded.
// req_if.ready is high only while idle; a stalled rsp_if holds the sequencer at its next
// response. Synchronous reset clears all active marks, the stored time and the order count.
module multi_slot_timer_scheduler import mst_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT,
   parameter int TICK_BITS = TICK_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   mst_req_if.sink    req_if,
   mst_rsp_if.source  rsp_if
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int TW = TICK_BITS;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_RELOAD = 6'b001000,
      ST_WRITE  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [TW-1:0]        now_ff, now_in;
   logic [STAMP_W-1:0]   order_ff, order_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;

   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [SW-1:0] cmp_idx_ff, cmp_idx_in;

   logic               best_vld_ff, best_vld_in;
   logic [SW-1:0]      best_idx_ff, best_idx_in;
   logic [TW-1:0]      best_diff_ff, best_diff_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [TW-1:0]      best_dl_ff, best_dl_in;
   logic [TW-1:0]      best_iv_ff, best_iv_in;
   logic [TW-1:0]      sum_ff, sum_in;

   logic [FIRE_CNT_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic                  pend_ff, pend_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [DELAY_W-1:0]    fin_delay_ff, fin_delay_in;
   logic                  fin_active_ff, fin_active_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_fired_ff, rsp_fired_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [DELAY_W-1:0] rsp_delay_ff, rsp_delay_in;
   logic               rsp_active_ff, rsp_active_in;

   // slot table
   logic [TW-1:0]      deadline_mem [NUM_SLOTS];
   logic [TW-1:0]      interval_mem [NUM_SLOTS];
   logic [STAMP_W-1:0] stamp_mem    [NUM_SLOTS];
   logic [TW-1:0]      rd_dl_ff, rd_iv_ff;
   logic [STAMP_W-1:0] rd_st_ff;

   logic               mem_we;
   logic [SW-1:0]      mem_wa;
   logic [TW-1:0]      mem_wd_dl, mem_wd_iv;
   logic [STAMP_W-1:0] mem_wd_st;
   logic [SW-1:0]      mem_ra;

   logic               out_free;
   logic               slot_ok;
   logic [SW-1:0]      slot_idx;
   logic [TW-1:0]      amount_t;
   logic [TW-1:0]      cand_diff;
   logic [STAMP_W-1:0] stamp_diff;
   logic               cand_better;
   logic               best_pos;
   logic [63:0]        best_diff_ext;
   logic [TW-1:0]      reload_diff;
   logic               reload_pos;
   logic [TW-1:0]      reload_dl;

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.fired_valid = rsp_fired_ff;
   assign rsp_if.fired_slot  = rsp_slot_ff;
   assign rsp_if.last        = rsp_last_ff;
   assign rsp_if.next_delay  = rsp_delay_ff;
   assign rsp_if.slot_active = rsp_active_ff;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign slot_ok  = (32'(req_if.slot) < 32'(NUM_SLOTS));
   assign slot_idx = SW'(req_if.slot);
   assign amount_t = TW'(req_if.amount);
   assign mem_ra   = scan_idx_ff[SW-1:0];

   // shared comparator: signed time-to-deadline, ties broken by older start stamp
   assign cand_diff   = rd_dl_ff - now_ff;
   assign stamp_diff  = rd_st_ff - best_stamp_ff;
   assign cand_better = ($signed(cand_diff) < $signed(best_diff_ff)) ||
                        ((cand_diff == best_diff_ff) && stamp_diff[STAMP_W-1]);

   assign best_pos      = (best_diff_ff != '0) && !best_diff_ff[TW-1];
   assign best_diff_ext = 64'(best_diff_ff);

   // reload point: old deadline + interval, or now + 1 if already missed
   assign reload_diff = sum_ff - now_ff;
   assign reload_pos  = (reload_diff != '0) && !reload_diff[TW-1];
   assign reload_dl   = reload_pos ? sum_ff : now_ff + TW'(1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         deadline_mem[mem_wa] <= mem_wd_dl;
         interval_mem[mem_wa] <= mem_wd_iv;
         stamp_mem[mem_wa]    <= mem_wd_st;
      end
      rd_dl_ff <= deadline_mem[mem_ra];
      rd_iv_ff <= interval_mem[mem_ra];
      rd_st_ff <= stamp_mem[mem_ra];
   end

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      order_in      = order_ff;
      active_in     = active_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      best_vld_in   = best_vld_ff;
      best_idx_in   = best_idx_ff;
      best_diff_in  = best_diff_ff;
      best_stamp_in = best_stamp_ff;
      best_dl_in    = best_dl_ff;
      best_iv_in    = best_iv_ff;
      sum_in        = sum_ff;
      fire_cnt_in   = fire_cnt_ff;
      pend_in       = pend_ff;
      pend_slot_in  = pend_slot_ff;
      fin_delay_in  = fin_delay_ff;
      fin_active_in = fin_active_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_fired_in  = rsp_fired_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_delay_in  = rsp_delay_ff;
      rsp_active_in = rsp_active_ff;
      mem_we        = 1'b0;
      mem_wa        = '0;
      mem_wd_dl     = '0;
      mem_wd_iv     = '0;
      mem_wd_st     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               pend_in       = 1'b0;
               fin_delay_in  = '0;
               fin_active_in = 1'b0;
               if (req_if.action == ACT_TICK) begin
                  now_in      = amount_t;
                  fire_cnt_in = '0;
                  scan_idx_in = '0;
                  best_vld_in = 1'b0;
                  state_in    = ST_SCAN;
               end else begin
                  if (slot_ok) begin
                     active_in[slot_idx] = 1'b0;
                     if (req_if.action != ACT_STOP) begin
                        active_in[slot_idx] = 1'b1;
                        fin_active_in       = 1'b1;
                        mem_we              = 1'b1;
                        mem_wa              = slot_idx;
                        mem_wd_dl           = now_ff + amount_t;
                        mem_wd_iv           = (req_if.action == ACT_START_ONESHOT) ?
                                              '0 : amount_t;
                        mem_wd_st           = order_ff;
                        order_in            = order_ff + STAMP_W'(1);
                     end
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff < CW'(NUM_SLOTS)) begin
               scan_idx_in = scan_idx_ff + CW'(1);
               cmp_vld_in  = 1'b1;
               cmp_idx_in  = scan_idx_ff[SW-1:0];
            end
            if (cmp_vld_ff && active_ff[cmp_idx_ff] && (!best_vld_ff || cand_better)) begin
               best_vld_in   = 1'b1;
               best_idx_in   = cmp_idx_ff;
               best_diff_in  = cand_diff;
               best_stamp_in = rd_st_ff;
               best_dl_in    = rd_dl_ff;
               best_iv_in    = rd_iv_ff;
            end
            if ((scan_idx_ff == CW'(NUM_SLOTS)) && !cmp_vld_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!best_vld_ff) begin
               fin_delay_in = '0;
               state_in     = ST_DONE;
            end else if (best_pos) begin
               fin_delay_in = (best_diff_ext > 64'(DELAY_MAX)) ?
                              DELAY_MAX : best_diff_ext[DELAY_W-1:0];
               state_in     = ST_DONE;
            end else if (fire_cnt_ff == FIRE_CNT_W'(MAX_FIRES)) begin
               fin_delay_in = DELAY_W'(1);
               state_in     = ST_DONE;
            end else begin
               state_in = ST_RELOAD;
            end
         end
         ST_RELOAD: begin
            sum_in   = best_dl_ff + best_iv_ff;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // the previous fired timer is reported once we know it is not the last
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_fired_in  = 1'b1;
                  rsp_slot_in   = pend_slot_ff;
                  rsp_last_in   = 1'b0;
                  rsp_delay_in  = '0;
                  rsp_active_in = 1'b0;
               end
               pend_in      = 1'b1;
               pend_slot_in = SLOT_W'(best_idx_ff);
               fire_cnt_in  = fire_cnt_ff + FIRE_CNT_W'(1);
               if (best_iv_ff != '0) begin
                  mem_we    = 1'b1;
                  mem_wa    = best_idx_ff;
                  mem_wd_dl = reload_dl;
                  mem_wd_iv = best_iv_ff;
                  mem_wd_st = order_ff;
                  order_in  = order_ff + STAMP_W'(1);
               end else begin
                  active_in[best_idx_ff] = 1'b0;
               end
               scan_idx_in = '0;
               best_vld_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_fired_in  = pend_ff;
               rsp_slot_in   = pend_ff ? pend_slot_ff : '0;
               rsp_last_in   = 1'b1;
               rsp_delay_in  = fin_delay_ff;
               rsp_active_in = fin_active_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         order_ff     <= '0;
         active_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         order_ff     <= order_in;
         active_ff    <= active_in;
         cmp_vld_ff   <= cmp_vld_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_vld_ff   <= best_vld_in;
      best_idx_ff   <= best_idx_in;
      best_diff_ff  <= best_diff_in;
      best_stamp_ff <= best_stamp_in;
      best_dl_ff    <= best_dl_in;
      best_iv_ff    <= best_iv_in;
      sum_ff        <= sum_in;
      fire_cnt_ff   <= fire_cnt_in;
      pend_slot_ff  <= pend_slot_in;
      fin_delay_ff  <= fin_delay_in;
      fin_active_ff <= fin_active_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_delay_ff  <= rsp_delay_in;
      rsp_active_ff <= rsp_active_in;
   end

endmodule

/* hdl/mst_checker.sv */
// Port-level checks for the timer scheduler, bound to the top level.
module mst_checker import mst_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_fired_valid,
   input logic               rsp_last,
   input logic [DELAY_W-1:0] rsp_next_delay,
   input logic               rsp_slot_active
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // one request in flight: ready falls right after a request is taken
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // only a fired timer report can be followed by more responses
   a_nonfired_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired_valid |-> rsp_last)
      else $error("non-fired response not marked last");

   a_mid_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> (rsp_next_delay == '0))
      else $error("next_delay set before last response");

   a_fired_no_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired_valid |-> !rsp_slot_active)
      else $error("slot_active set on fired report");

endmodule

bind multi_slot_timer_scheduler mst_checker u_mst_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_if.valid),
   .req_ready       (req_if.ready),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_fired_valid (rsp_if.fired_valid),
   .rsp_last        (rsp_if.last),
   .rsp_next_delay  (rsp_if.next_delay),
   .rsp_slot_active (rsp_if.slot_active)
);
